### design/rpgf_pkg.sv
// Shared constants and types of the rotary position glitch filter.
package rpgf_pkg;

    localparam int DEF_NUM_POSITIONS = 8;
    localparam int DEF_CODE_BITS     = 4;

    // Widest position code over the supported range of position counts.
    localparam int MAX_POS_W = 5;

    localparam int TIME_W     = 32;
    localparam int TIMEOUT_W  = 16;
    localparam int REP_W      = 4;
    localparam int DIR_W      = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;
    localparam int TABLE_W    = 32;

    localparam logic [REP_W-1:0]     REPEAT_THRESHOLD_RST = 4'd3;
    localparam logic [TIMEOUT_W-1:0] STEP_TIMEOUT_RST     = 16'd700;
    localparam logic [REP_W-1:0]     REP_MAX              = 4'hF;

    localparam logic [CFG_IDX_W-1:0] REG_CODE_TABLE       = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_REPEAT_THRESHOLD = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_TIMEOUT     = 2'd2;

    localparam logic [DIR_W-1:0] DIR_STOP = 2'b00;
    localparam logic [DIR_W-1:0] DIR_FWD  = 2'b01;

    typedef struct packed {
        logic                 hit;
        logic [MAX_POS_W-1:0] pos;
    } match_t;

endpackage

### design/rpgf_match.sv
// Code table lookup: finds the lowest position whose table code equals the sensor code.
module rpgf_match import rpgf_pkg::*; #(
    parameter int NUM_POSITIONS = DEF_NUM_POSITIONS,
    parameter int CODE_BITS     = DEF_CODE_BITS
) (
    input  logic [TABLE_W-1:0]   code_table,
    input  logic [CODE_BITS-1:0] sensor_code,
    output match_t               match
);

    localparam int SPAN_W = NUM_POSITIONS * CODE_BITS;
    localparam int EXT_W  = (SPAN_W > TABLE_W) ? SPAN_W : TABLE_W;

    // Entries that reach past the register read as zero bits.
    logic [EXT_W-1:0] table_ext;

    assign table_ext = EXT_W'(code_table);

    always_comb begin
        match = '0;
        // Walk from the top so that the lowest matching position wins.
        for (int k = NUM_POSITIONS - 1; k >= 0; k--) begin
            if (table_ext[k*CODE_BITS +: CODE_BITS] == sensor_code) begin
                match.hit = 1'b1;
                match.pos = MAX_POS_W'(k + 1);
            end
        end
    end

endmodule

### design/rotary_position_glitch_filter_unit.sv
// Flow: a taken input beat is held in the input register, and the result register loads
// from it once the result register is empty or its beat is being taken on m_tready.
// Throughput: one input beat per cycle while the result register drains; the input register
// and the result register let a new beat enter while a finished result waits on m_tready.
// Reset (aresetn low, synchronous): both registers empty, no position accepted,
// rejection count cleared, code table zero, threshold 3 and timeout 700 ms.
// All filtering is combinational between the input and result registers.
module rotary_position_glitch_filter_unit import rpgf_pkg::*; #(
    parameter int NUM_POSITIONS = DEF_NUM_POSITIONS,
    parameter int CODE_BITS     = DEF_CODE_BITS,
    localparam int POS_W        = $clog2(NUM_POSITIONS + 1),
    localparam int IN_W         = CODE_BITS + DIR_W + TIME_W,
    localparam int IN_TDATA_W   = ((IN_W + 7) / 8) * 8,
    localparam int OUT_W        = POS_W + 2,
    localparam int OUT_TDATA_W  = ((OUT_W + 7) / 8) * 8
) (
    input  logic                   aclk,
    input  logic                   aresetn,

    input  logic                   cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,

    input  logic                   s_tvalid,
    output logic                   s_tready,
    // From bit 0: sensor_code, move_dir, now_ms, zero fill.
    input  logic [IN_TDATA_W-1:0]  s_tdata,

    output logic                   m_tvalid,
    input  logic                   m_tready,
    // From bit 0: position, code_matched, newly_accepted, zero fill.
    output logic [OUT_TDATA_W-1:0] m_tdata
);

    // Configuration registers.
    logic [TABLE_W-1:0]   code_table_reg;
    logic [REP_W-1:0]     threshold_reg;
    logic [TIMEOUT_W-1:0] timeout_reg;

    // Input register.
    logic                 in_valid_reg;
    logic [CODE_BITS-1:0] code_reg;
    logic [DIR_W-1:0]     dir_reg;
    logic [TIME_W-1:0]    now_reg;

    // Filter state.
    logic [POS_W-1:0]     acc_pos_reg, acc_pos_next;
    logic [POS_W-1:0]     rej_pos_reg, rej_pos_next;
    logic [REP_W-1:0]     rej_cnt_reg, rej_cnt_next;
    logic [TIME_W-1:0]    acc_time_reg, acc_time_next;

    // Result register.
    logic                 out_valid_reg;
    logic [POS_W-1:0]     out_pos_reg;
    logic                 out_hit_reg;
    logic                 out_fresh_reg;

    match_t               match;
    logic [POS_W-1:0]     raw_pos;
    logic [POS_W-1:0]     expected;
    logic [REP_W-1:0]     rep_count;
    logic [TIME_W-1:0]    elapsed;
    logic                 fresh;
    logic                 advance;

    rpgf_match #(
        .NUM_POSITIONS (NUM_POSITIONS),
        .CODE_BITS     (CODE_BITS)
    ) u_match (
        .code_table  (code_table_reg),
        .sensor_code (code_reg),
        .match       (match)
    );

    assign raw_pos  = match.pos[POS_W-1:0];
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign elapsed  = now_reg - acc_time_reg;

    always_comb begin
        if (dir_reg == DIR_FWD) begin
            expected = (acc_pos_reg >= POS_W'(NUM_POSITIONS)) ? POS_W'(1) : acc_pos_reg + 1'b1;
        end else begin
            expected = (acc_pos_reg <= POS_W'(1)) ? POS_W'(NUM_POSITIONS) : acc_pos_reg - 1'b1;
        end
    end

    always_comb begin
        if (raw_pos == rej_pos_reg) begin
            rep_count = (rej_cnt_reg == REP_MAX) ? REP_MAX : rej_cnt_reg + 1'b1;
        end else begin
            rep_count = REP_W'(1);
        end
    end

    always_comb begin
        fresh         = 1'b0;
        acc_pos_next  = acc_pos_reg;
        rej_pos_next  = rej_pos_reg;
        rej_cnt_next  = rej_cnt_reg;
        acc_time_next = acc_time_reg;
        if (match.hit) begin
            if (acc_pos_reg == '0) begin
                fresh = 1'b1;
            end else if (dir_reg != DIR_STOP && raw_pos != acc_pos_reg) begin
                if (raw_pos == expected) begin
                    fresh = 1'b1;
                end else if (rep_count >= threshold_reg ||
                             elapsed > TIME_W'(timeout_reg)) begin
                    fresh = 1'b1;
                end else begin
                    rej_pos_next = raw_pos;
                    rej_cnt_next = rep_count;
                end
            end
        end
        if (fresh) begin
            acc_pos_next  = raw_pos;
            rej_pos_next  = '0;
            rej_cnt_next  = '0;
            acc_time_next = now_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            code_table_reg <= '0;
            threshold_reg  <= REPEAT_THRESHOLD_RST;
            timeout_reg    <= STEP_TIMEOUT_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_CODE_TABLE:       code_table_reg <= cfg_data[TABLE_W-1:0];
                REG_REPEAT_THRESHOLD: threshold_reg  <= cfg_data[REP_W-1:0];
                REG_STEP_TIMEOUT:     timeout_reg    <= cfg_data[TIMEOUT_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
        if (s_tvalid && s_tready) begin
            code_reg <= s_tdata[CODE_BITS-1:0];
            dir_reg  <= s_tdata[CODE_BITS +: DIR_W];
            now_reg  <= s_tdata[CODE_BITS+DIR_W +: TIME_W];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_pos_reg  <= '0;
            rej_pos_reg  <= '0;
            rej_cnt_reg  <= '0;
            acc_time_reg <= '0;
        end else if (advance) begin
            acc_pos_reg  <= acc_pos_next;
            rej_pos_reg  <= rej_pos_next;
            rej_cnt_reg  <= rej_cnt_next;
            acc_time_reg <= acc_time_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
        if (advance) begin
            out_pos_reg   <= acc_pos_next;
            out_hit_reg   <= match.hit;
            out_fresh_reg <= fresh;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_TDATA_W'({out_fresh_reg, out_hit_reg, out_pos_reg});

    // The accepted position stays within the table.
    a_pos_range: assert property (@(posedge aclk) disable iff (!aresetn)
        acc_pos_reg <= POS_W'(NUM_POSITIONS))
        else $error("accepted position out of range");

    // An acceptance always comes from a matched code.
    a_fresh_hit: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && out_fresh_reg |-> out_hit_reg && out_pos_reg != '0)
        else $error("acceptance without a matched code");

    // An acceptance clears the rejection tracking.
    a_fresh_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && fresh |=> rej_pos_reg == '0 && rej_cnt_reg == '0)
        else $error("rejection state not cleared on acceptance");

    // Once a position is accepted the filter never returns to none.
    a_pos_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        acc_pos_reg != '0 |=> acc_pos_reg != '0)
        else $error("accepted position lost");

    // Back pressure on the input only while the input register is occupied.
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> in_valid_reg && out_valid_reg && !m_tready)
        else $error("input stalled without cause");

endmodule

### dv/tb_top.sv
// Self-checking testbench for the rotary position glitch filter unit.
`timescale 1ns / 100ps

module tb_top;
    import rpgf_pkg::*;

    localparam int NPOS        = DEF_NUM_POSITIONS;
    localparam int CODE_W      = DEF_CODE_BITS;
    localparam int POS_W       = $clog2(NPOS + 1);
    localparam int IN_W        = CODE_W + DIR_W + TIME_W;
    localparam int IN_TDATA_W  = ((IN_W + 7) / 8) * 8;
    localparam int OUT_W       = POS_W + 2;
    localparam int OUT_TDATA_W = ((OUT_W + 7) / 8) * 8;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int PHASE_BEATS = 127;
    localparam int RANDOM_PHASES = 12;

    // Both negative direction codes count as backward.
    localparam logic [DIR_W-1:0] DIR_BACK     = 2'b11;
    localparam logic [DIR_W-1:0] DIR_BACK_ALT = 2'b10;

    typedef struct packed {
        logic             fresh;
        logic             matched;
        logic [POS_W-1:0] pos;
    } filter_result_t;

    class position_scoreboard;
        logic [TABLE_W-1:0]   code_table;
        logic [REP_W-1:0]     repeat_threshold;
        logic [TIMEOUT_W-1:0] step_timeout;
        logic [POS_W-1:0]     accepted_pos;
        logic [POS_W-1:0]     rejected_pos;
        logic [REP_W-1:0]     reject_repeats;
        logic [TIME_W-1:0]    accept_time;
        filter_result_t       pending_outputs[$];
        int                   errors;

        function new();
            code_table       = '0;
            repeat_threshold = REPEAT_THRESHOLD_RST;
            step_timeout     = STEP_TIMEOUT_RST;
            accepted_pos     = '0;
            rejected_pos     = '0;
            reject_repeats   = '0;
            accept_time      = '0;
            errors           = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_CODE_TABLE:       code_table = data[TABLE_W-1:0];
                REG_REPEAT_THRESHOLD: repeat_threshold = data[REP_W-1:0];
                REG_STEP_TIMEOUT:     step_timeout = data[TIMEOUT_W-1:0];
                default: ;
            endcase
        endfunction

        function logic [POS_W-1:0] lookup_pos(logic [CODE_W-1:0] code);
            logic [POS_W-1:0] hit;
            hit = '0;
            // Scanning downward leaves the lowest matching position in hit.
            for (int k = NPOS - 1; k >= 0; k--) begin
                if (code_table[k*CODE_W +: CODE_W] == code) begin
                    hit = POS_W'(k + 1);
                end
            end
            return hit;
        endfunction

        function void take_position(logic [POS_W-1:0] pos, logic [TIME_W-1:0] now);
            accepted_pos   = pos;
            rejected_pos   = '0;
            reject_repeats = '0;
            accept_time    = now;
        endfunction

        function void note_reading(logic [CODE_W-1:0] code, logic [DIR_W-1:0] dir,
                                   logic [TIME_W-1:0] now);
            logic [POS_W-1:0]  raw;
            logic [POS_W-1:0]  next_pos;
            logic [TIME_W-1:0] elapsed;
            filter_result_t    res;
            raw         = lookup_pos(code);
            res.matched = (raw != '0);
            res.fresh   = 1'b0;
            if (raw != '0) begin
                if (accepted_pos == '0) begin
                    take_position(raw, now);
                    res.fresh = 1'b1;
                end else if (dir != DIR_STOP && raw != accepted_pos) begin
                    if (dir == DIR_FWD) begin
                        next_pos = (accepted_pos >= NPOS) ? POS_W'(1) : accepted_pos + 1'b1;
                    end else begin
                        next_pos = (accepted_pos <= 1) ? POS_W'(NPOS) : accepted_pos - 1'b1;
                    end
                    if (raw == next_pos) begin
                        take_position(raw, now);
                        res.fresh = 1'b1;
                    end else begin
                        if (raw == rejected_pos) begin
                            if (reject_repeats < REP_MAX) begin
                                reject_repeats = reject_repeats + 1'b1;
                            end
                        end else begin
                            rejected_pos   = raw;
                            reject_repeats = REP_W'(1);
                        end
                        elapsed = now - accept_time;
                        if (reject_repeats >= repeat_threshold ||
                            elapsed > TIME_W'(step_timeout)) begin
                            take_position(raw, now);
                            res.fresh = 1'b1;
                        end
                    end
                end
            end
            res.pos = accepted_pos;
            pending_outputs.push_back(res);
        endfunction

        task report(string msg);
            $display("%0t: %s", $time, msg);
            errors++;
        endtask

        task check_filter_output(filter_result_t got);
            filter_result_t want;
            if (pending_outputs.size() == 0) begin
                report($sformatf("result beat with nothing pending (position %0d)", got.pos));
            end else begin
                want = pending_outputs.pop_front();
                if (got.pos !== want.pos)
                    report($sformatf("position got %0d, want %0d", got.pos, want.pos));
                if (got.matched !== want.matched)
                    report($sformatf("code_matched got %0b, want %0b", got.matched, want.matched));
                if (got.fresh !== want.fresh)
                    report($sformatf("newly_accepted got %0b, want %0b", got.fresh, want.fresh));
            end
        endtask
    endclass

    logic                   aclk = 1'b0;
    logic                   aresetn;
    logic                   cfg_wr_en;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;

    position_scoreboard sb;
    logic [TABLE_W-1:0] cur_table;
    logic [TIME_W-1:0]  now_t;
    int                 tx_gap_pct;
    int                 rx_stall_pct;
    bit                 hold_rx;
    int                 beats_in;
    int                 cycle_count = 0;

    rotary_position_glitch_filter_unit #(
        .NUM_POSITIONS(NPOS),
        .CODE_BITS    (CODE_W)
    ) u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_wr_en(cfg_wr_en),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            sb.check_filter_output(filter_result_t'(m_tdata[OUT_W-1:0]));
        end
    end

    // Mostly short gaps, now and then a long one.
    function int pick_gap();
        return ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(12, 40);
    endfunction

    function logic [CODE_W-1:0] code_of(int p);
        return cur_table[(p - 1)*CODE_W +: CODE_W];
    endfunction

    function logic [TABLE_W-1:0] make_table(bit dup);
        logic [CODE_W-1:0]  perm[16];
        logic [CODE_W-1:0]  tmp;
        logic [TABLE_W-1:0] tbl;
        int                 j;
        int                 a;
        int                 b;
        for (int i = 0; i < 16; i++) perm[i] = CODE_W'(i);
        for (int i = 15; i > 0; i--) begin
            j       = $urandom_range(0, i);
            tmp     = perm[i];
            perm[i] = perm[j];
            perm[j] = tmp;
        end
        for (int k = 0; k < NPOS; k++) tbl[k*CODE_W +: CODE_W] = perm[k];
        if (dup) begin
            a = $urandom_range(0, NPOS - 1);
            b = (a + $urandom_range(1, NPOS - 1)) % NPOS;
            tbl[b*CODE_W +: CODE_W] = tbl[a*CODE_W +: CODE_W];
        end
        return tbl;
    endfunction

    task feed_reading(logic [CODE_W-1:0] code, logic [DIR_W-1:0] dir, logic [TIME_W-1:0] now);
        int len;
        @(negedge aclk);
        s_tvalid = 1'b1;
        s_tdata  = {{(IN_TDATA_W - IN_W){1'b0}}, now, dir, code};
        do @(posedge aclk); while (!s_tready);
        sb.note_reading(code, dir, now);
        beats_in++;
        if (tx_gap_pct > 0 && $urandom_range(0, 99) < tx_gap_pct) begin
            len = pick_gap();
            @(negedge aclk);
            s_tvalid = 1'b0;
            repeat (len - 1) @(negedge aclk);
        end
    endtask

    task wait_idle();
        @(negedge aclk);
        s_tvalid = 1'b0;
        while (sb.pending_outputs.size() != 0) @(posedge aclk);
        repeat (3) @(posedge aclk);
    endtask

    task write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(negedge aclk);
        cfg_wr_en = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        @(negedge aclk);
        cfg_wr_en = 1'b0;
        sb.write_reg(idx, data);
        if (idx == REG_CODE_TABLE) cur_table = data[TABLE_W-1:0];
    endtask

    task configure(logic [TABLE_W-1:0] tbl, logic [REP_W-1:0] thr, logic [TIMEOUT_W-1:0] tmo);
        wait_idle();
        write_reg(REG_CODE_TABLE, CFG_DATA_W'(tbl));
        write_reg(REG_REPEAT_THRESHOLD, CFG_DATA_W'(thr));
        write_reg(REG_STEP_TIMEOUT, CFG_DATA_W'(tmo));
    endtask

    // Mostly a turntable stepping through neighbors, with glitch bursts that
    // repeat one reading and a share of raw noise.
    task random_phase(int n);
        logic [DIR_W-1:0]  motor;
        logic [DIR_W-1:0]  dir;
        logic [CODE_W-1:0] code;
        logic [CODE_W-1:0] glitch_code;
        int                base;
        int                burst;
        int                r;
        motor = DIR_FWD;
        burst = 0;
        glitch_code = '0;
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 19) == 0) motor = DIR_W'($urandom_range(0, 3));
            dir = motor;
            if (burst > 0) begin
                code = glitch_code;
                burst--;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 70) begin
                    base = (sb.accepted_pos == '0) ? 1 : int'(sb.accepted_pos);
                    if ($urandom_range(0, 2) != 0 && motor != DIR_STOP) begin
                        if (motor == DIR_FWD) base = base % NPOS + 1;
                        else base = (base == 1) ? NPOS : base - 1;
                    end
                    code = code_of(base);
                end else if (r < 84) begin
                    glitch_code = code_of($urandom_range(1, NPOS));
                    burst = $urandom_range(0, 5);
                    code = glitch_code;
                end else if (r < 94) begin
                    code = CODE_W'($urandom_range(0, 15));
                end else begin
                    code = CODE_W'($urandom);
                    dir  = DIR_W'($urandom);
                end
            end
            r = $urandom_range(0, 19);
            if (r < 16) now_t = now_t + TIME_W'($urandom_range(0, 60));
            else if (r < 19) now_t = now_t + TIME_W'($urandom_range(400, 1500));
            else now_t = now_t + TIME_W'($urandom);
            feed_reading(code, dir, now_t);
        end
    endtask

    initial begin
        int stall;
        stall = 0;
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_rx) begin
                m_tready = 1'b0;
            end else if (stall > 0) begin
                m_tready = 1'b0;
                stall--;
            end else begin
                m_tready = 1'b1;
                if (rx_stall_pct > 0 && $urandom_range(0, 99) < rx_stall_pct) stall = pick_gap();
            end
        end
    end

    // One long receiver hold-off in the middle of the random traffic, so the
    // block fills up and pushes back on its input.
    initial begin
        hold_rx = 1'b0;
        wait (beats_in >= 600);
        hold_rx = 1'b1;
        repeat (400) @(posedge aclk);
        hold_rx = 1'b0;
    end

    initial begin
        sb           = new();
        aresetn      = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        cfg_wr_en    = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        tx_gap_pct   = 0;
        rx_stall_pct = 0;
        beats_in     = 0;
        cur_table    = '0;
        now_t        = '0;
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Reset table is all zero: only code 0 matches, as position 1.
        feed_reading(4'hF, DIR_FWD, 32'd0);
        feed_reading(4'h0, DIR_STOP, 32'd5);

        configure(32'hFEDC_BA98, REPEAT_THRESHOLD_RST, STEP_TIMEOUT_RST);
        feed_reading(code_of(1), DIR_FWD, 32'd100);
        feed_reading(code_of(2), DIR_FWD, 32'd101);
        feed_reading(code_of(1), DIR_BACK, 32'd102);
        feed_reading(code_of(8), DIR_BACK_ALT, 32'd103);
        feed_reading(code_of(1), DIR_FWD, 32'd104);
        feed_reading(code_of(5), DIR_FWD, 32'd105);
        feed_reading(code_of(5), DIR_FWD, 32'd106);
        feed_reading(code_of(5), DIR_FWD, 32'd107);
        feed_reading(code_of(2), DIR_STOP, 32'd108);
        feed_reading(4'h3, DIR_FWD, 32'd109);
        feed_reading(code_of(7), DIR_FWD, 32'd110);
        // Exactly the timeout is not enough; one more millisecond is.
        feed_reading(code_of(3), DIR_FWD, 32'd807);
        feed_reading(code_of(3), DIR_FWD, 32'd808);
        feed_reading(code_of(4), DIR_FWD, 32'hFFFF_FFFF);
        // Elapsed time across the wrap of the millisecond counter.
        feed_reading(code_of(6), DIR_BACK, 32'h0000_0100);
        feed_reading(code_of(6), DIR_BACK, 32'h0000_02BC);
        feed_reading(4'h0, DIR_STOP, 32'h0000_02BD);
        feed_reading(4'hF, DIR_BACK_ALT, 32'h0000_02BE);
        now_t = 32'h0000_0300;

        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            case (ph)
                0: begin
                    tx_gap_pct = 20; rx_stall_pct = 20;
                    configure(make_table(1'b0), 4'd3, 16'd700);
                end
                1: begin
                    tx_gap_pct = 10; rx_stall_pct = 30;
                    configure(make_table(1'b0), 4'd0, 16'($urandom_range(0, 2000)));
                end
                2: begin
                    tx_gap_pct = 30; rx_stall_pct = 10;
                    configure(make_table(1'b0), 4'd15, 16'hFFFF);
                end
                3: begin
                    tx_gap_pct = 5; rx_stall_pct = 5;
                    configure(make_table(1'b0), 4'd1, 16'd0);
                end
                4: begin
                    tx_gap_pct = 15; rx_stall_pct = 15;
                    configure(32'hFFFF_FFFF, 4'd2, 16'd300);
                end
                5: begin
                    tx_gap_pct = 15; rx_stall_pct = 15;
                    configure(32'h0000_0000, 4'd4, 16'd100);
                end
                6: begin
                    tx_gap_pct = 20; rx_stall_pct = 20;
                    configure(make_table(1'b1), 4'd3, 16'd500);
                end
                7: begin
                    tx_gap_pct = 0; rx_stall_pct = 0;
                    configure(make_table(1'b0), 4'd2, 16'd700);
                end
                8: begin
                    tx_gap_pct = 15; rx_stall_pct = 15;
                    configure(make_table(1'b0), 4'd5, 16'd1000);
                    now_t = 32'hFFFF_F000;
                end
                default: begin
                    tx_gap_pct   = $urandom_range(0, 40);
                    rx_stall_pct = $urandom_range(0, 40);
                    configure(make_table($urandom_range(0, 3) == 0),
                              4'($urandom_range(0, 15)),
                              ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 65535))
                                                          : 16'($urandom_range(0, 1500)));
                end
            endcase
            random_phase(PHASE_BEATS);
        end

        wait_idle();
        repeat (10) @(posedge aclk);
        if (sb.errors == 0 && sb.pending_outputs.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
